### src/upd_pkg.sv
`default_nettype none
package upd_pkg;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int unsigned MAX_RESULTS = 3;

  // Up to three decoded bytes produced by one input transfer, in output order.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [1:0]                  cnt;
    logic                        last;
  } upd_bundle_t;

endpackage
`default_nettype wire

### src/upd_front.sv
`default_nettype none
module upd_front
  import upd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tlast,
  input  wire logic        q_full,
  output logic             q_push,
  output upd_bundle_t      q_wdata
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       accept;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) ||
             (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Letters have low nibbles 1..6, so adding 9 gives 10..15 in either case.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    hex_val = c[6] ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

  always_comb begin
    logic [MAX_RESULTS-1:0][7:0] slots;
    logic [1:0] n;
    logic       fresh;
    slots     = '0;
    n         = 2'd0;
    fresh     = 1'b0;
    phase_nxt = phase_r;
    held_nxt  = held_r;

    case (phase_r)
      PH_PCT: begin
        if (is_hex(in_tdata)) begin
          held_nxt  = in_tdata;
          phase_nxt = PH_DIGIT;
        end else begin
          slots[n] = CH_PCT;
          n        = n + 2'd1;
          fresh    = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (is_hex(in_tdata)) begin
          slots[n]  = {hex_val(held_r), hex_val(in_tdata)};
          n         = n + 2'd1;
          phase_nxt = PH_IDLE;
        end else begin
          slots[n] = CH_PCT;
          n        = n + 2'd1;
          slots[n] = held_r;
          n        = n + 2'd1;
          fresh    = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    // The byte that broke a sequence, or a byte with nothing pending.
    if (fresh) begin
      phase_nxt = PH_IDLE;
      if (in_tdata == CH_PCT) begin
        phase_nxt = PH_PCT;
      end else if (in_tdata == CH_PLUS) begin
        slots[n] = CH_SPACE;
        n        = n + 2'd1;
      end else begin
        slots[n] = in_tdata;
        n        = n + 2'd1;
      end
    end

    // End of string flushes whatever is still pending.
    if (in_tlast) begin
      if (phase_nxt == PH_PCT) begin
        slots[n] = CH_PCT;
        n        = n + 2'd1;
      end else if (phase_nxt == PH_DIGIT) begin
        slots[n] = CH_PCT;
        n        = n + 2'd1;
        slots[n] = held_nxt;
        n        = n + 2'd1;
      end
      phase_nxt = PH_IDLE;
      held_nxt  = 8'h00;
    end

    q_wdata.bytes = slots;
    q_wdata.cnt   = n;
    q_wdata.last  = in_tlast;
  end

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept && (q_wdata.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'h00;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule
`default_nettype wire

### src/upd_queue.sv
`default_nettype none
module upd_queue
  import upd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire upd_bundle_t wdata,
  output logic             full,
  input  wire logic        pop,
  output upd_bundle_t      rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  upd_bundle_t        mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

### src/upd_back.sv
`default_nettype none
module upd_back
  import upd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_empty,
  input  wire upd_bundle_t q_rdata,
  output logic             q_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast
);

  upd_bundle_t cur_r;
  logic        cur_valid_r;
  logic [1:0]  idx_r;
  logic        on_final;
  logic        fire;
  logic        done;

  assign on_final   = (idx_r == cur_r.cnt - 2'd1);
  assign fire       = out_tvalid && out_tready;
  assign done       = fire && on_final;
  assign q_pop      = !q_empty && (!cur_valid_r || done);

  assign out_tvalid = cur_valid_r;
  assign out_tdata  = cur_r.bytes[idx_r];
  assign out_tlast  = cur_r.last && on_final;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= 2'd0;
    end else if (done) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (fire) begin
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule
`default_nettype wire

### src/url_percent_decoder_core.sv
// URL percent decoder. Encoded characters enter on the in_ stream, one per
// transfer, with in_tlast on the final character of a string. Decoded
// characters leave on the out_ stream; out_tlast marks the final decoded
// character of that string. "%hh" becomes one byte, '+' becomes a space,
// and a broken escape is passed through literally.
// The front decodes one input transfer per cycle while the queue is not
// full, into a group of zero to three output bytes, and writes it into a
// FIFO_DEPTH-entry queue; the back plays each group out one byte per cycle
// while out_tready is high, from its output register. An input's first
// output byte passes through the queue and then that output register.
// Throughput is one input per cycle while out_tready is high and each
// input yields one byte at most; more bytes hold the back end until sent.
// When out_tready is low the back holds its byte, the queue fills, and
// in_tready drops once the queue is full. Inputs that yield nothing (a
// pending '%' or its first digit) never occupy the queue.
// Reset clears the pending escape state and empties the queue.
`default_nettype none
module url_percent_decoder_core
  import upd_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast
);

  upd_bundle_t push_data;
  upd_bundle_t pop_data;
  logic        push, pop, full, empty;

  upd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (full),
    .q_push    (push),
    .q_wdata   (push_data)
  );

  upd_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_data),
    .full  (full),
    .pop   (pop),
    .rdata (pop_data),
    .empty (empty)
  );

  upd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (empty),
    .q_rdata    (pop_data),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

### tb/tb_url_percent_decoder_core.sv
`timescale 1ns / 100ps
module tb_url_percent_decoder_core;
  import upd_pkg::*;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_phase_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         drain;
  } enc_char_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } dec_char_t;

  localparam int RANDOM_ITEMS = 210;
  localparam int HOLD_CYCLES  = 200;
  localparam int HOLD_AFTER   = 40;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] in_byte
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic       out_tlast;

  enc_char_t  enc_queue[$];
  dec_char_t  decoded_queue[$];
  enc_char_t  next_char;
  dec_char_t  oldest_dec;
  int         total_chars;
  int         accepted_cnt = 0;
  int         err_cnt = 0;

  // Shadow of the decoder's escape state.
  esc_phase_t esc_phase = ESC_NONE;
  logic [7:0] esc_digit = 8'h00;

  int tx_gap = 0;
  int tx_calm = 0;
  int rx_gap = 0;
  int rx_calm = 0;
  int rx_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  url_percent_decoder_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic bit is_hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c >= "a") v = c - "a" + 8'd10;
    else if (c >= "A") v = c - "A" + 8'd10;
    else v = c - "0";
    return v[3:0];
  endfunction

  // Decode one accepted character and queue the bytes it releases.
  task automatic decode_char(input logic [7:0] c, input logic last);
    logic [7:0] res[$];
    bit         reexamine;
    reexamine = 1'b0;
    case (esc_phase)
      ESC_PCT: begin
        if (is_hex_char(c)) begin
          esc_digit = c;
          esc_phase = ESC_DIGIT;
        end else begin
          res.push_back(CH_PCT);
          esc_phase = ESC_NONE;
          reexamine = 1'b1;
        end
      end
      ESC_DIGIT: begin
        esc_phase = ESC_NONE;
        if (is_hex_char(c)) begin
          res.push_back({hex_nibble(esc_digit), hex_nibble(c)});
        end else begin
          res.push_back(CH_PCT);
          res.push_back(esc_digit);
          reexamine = 1'b1;
        end
      end
      default: begin
        esc_phase = ESC_NONE;
        reexamine = 1'b1;
      end
    endcase
    if (reexamine) begin
      if (c == CH_PCT) esc_phase = ESC_PCT;
      else if (c == CH_PLUS) res.push_back(CH_SPACE);
      else res.push_back(c);
    end
    if (last) begin
      if (esc_phase == ESC_PCT) begin
        res.push_back(CH_PCT);
      end else if (esc_phase == ESC_DIGIT) begin
        res.push_back(CH_PCT);
        res.push_back(esc_digit);
      end
      esc_phase = ESC_NONE;
      esc_digit = 8'h00;
    end
    foreach (res[i]) begin
      decoded_queue.push_back('{data: res[i], last: last && (i == res.size() - 1)});
    end
  endtask

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_char(input logic [7:0] c, input logic last = 1'b0);
    enc_queue.push_back('{data: c, last: last, drain: 1'b0});
  endtask

  function automatic logic [7:0] rand_hex();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return 8'("0" + k);
    if (k < 16) return 8'("A" + (k - 10));
    return 8'("a" + (k - 16));
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (is_hex_char(c));
    return c;
  endfunction

  // Driver: presents queued characters with random gaps between transfers.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_char(in_tdata, in_tlast);
        accepted_cnt++;
      end
      if (in_tvalid && !in_tready) begin
        // Hold the offered character until it is taken.
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_tvalid <= 1'b0;
      end else if (enc_queue.size() > 0 &&
                   !(enc_queue[0].drain && decoded_queue.size() != 0)) begin
        next_char = enc_queue.pop_front();
        in_tdata  <= next_char.data;
        in_tlast  <= next_char.last;
        in_tvalid <= 1'b1;
        tx_gap = pick_gap(tx_calm);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the input side backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) rx_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && rx_cnt >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else begin
        if (out_tvalid && out_tready) rx_gap = pick_gap(rx_calm);
        out_tready <= (rx_gap == 0);
      end
    end
  end

  // Monitor: every output transfer must match the oldest decoded byte.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", out_tdata, out_tlast));
      end else begin
        oldest_dec = decoded_queue.pop_front();
        if (out_tdata !== oldest_dec.data)
          report_mismatch($sformatf("byte %02h, wanted %02h", out_tdata, oldest_dec.data));
        if (out_tlast !== oldest_dec.last)
          report_mismatch($sformatf("last %0b, wanted %0b on byte %02h",
                                    out_tlast, oldest_dec.last, oldest_dec.data));
      end
    end
  end

  initial begin
    int seg;
    int directed_n;
    bit drain_set;

    // Escapes including both value extremes, in both cases of hex digits.
    add_char(CH_PCT); add_char("4"); add_char("1");
    add_char(CH_PCT); add_char("f"); add_char("F");
    add_char(CH_PCT); add_char("0"); add_char("0");
    add_char(CH_PLUS);
    // A zero byte and a non-ASCII byte pass through unchanged.
    add_char(8'h00);
    add_char(8'hFF);
    add_char("a", 1'b1);
    // A lone percent sign as the final character.
    add_char(CH_PCT, 1'b1);
    // A percent and one digit flushed by the final flag.
    add_char(CH_PCT); add_char("4", 1'b1);
    // Broken escapes: the breaking character yields a byte of its own or starts a new escape.
    add_char(CH_PCT); add_char("4"); add_char(CH_PLUS, 1'b1);
    add_char(CH_PCT); add_char(CH_PCT); add_char("4"); add_char("1");
    add_char(CH_PCT); add_char("4"); add_char("G");
    directed_n = enc_queue.size();

    drain_set = 1'b0;
    while (enc_queue.size() - directed_n < RANDOM_ITEMS) begin
      seg = $urandom_range(0, 99);
      if (seg < 40) begin
        add_char(CH_PCT); add_char(rand_hex()); add_char(rand_hex());
      end else if (seg < 55) begin
        add_char(rand_non_hex());
      end else if (seg < 65) begin
        add_char(CH_PLUS);
      end else if (seg < 75) begin
        add_char(CH_PCT); add_char(rand_non_hex());
      end else if (seg < 85) begin
        add_char(CH_PCT); add_char(rand_hex()); add_char(rand_non_hex());
      end else begin
        add_char(8'($urandom_range(1, 255)));
      end
      if ($urandom_range(0, 7) == 0) enc_queue[$].last = 1'b1;
      // Let everything drain once before the directed part's follow-on and mid-run.
      if (enc_queue.size() == directed_n + 1 ||
          (!drain_set && enc_queue.size() - directed_n >= 150)) begin
        enc_queue[$].drain = 1'b1;
        if (enc_queue.size() - directed_n >= 150) drain_set = 1'b1;
      end
    end
    enc_queue[$].last = 1'b1;
    total_chars = enc_queue.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt != total_chars || decoded_queue.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (decoded_queue.size() != 0)
      report_mismatch($sformatf("%0d decoded bytes never arrived", decoded_queue.size()));

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
